@@ rtl/chg_pkg.sv @@
// Shared constants, types and the denomination table of the change dispenser.
`timescale 1ns / 1ps

package chg_pkg;

    localparam int NUM_DENOMS         = 13;
    localparam int SLOT_W             = 4;
    localparam int VAL_W              = 15;
    localparam int REM_W              = 24;
    localparam int BAL_W              = 32;
    localparam int PIECES_W           = 16;
    localparam int STOCK_IN_W         = 16;
    localparam int STATUS_W           = 3;
    localparam int COUNT_BITS_DEFAULT = 16;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_SALE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_LOADED       = 3'd0,
        STATUS_CHANGE_PART  = 3'd1,
        STATUS_NO_CHANGE    = 3'd2,
        STATUS_UNDERPAID    = 3'd3,
        STATUS_INSUFFICIENT = 3'd4
    } chg_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD_MUL,
        ST_LOAD_ADD,
        ST_WALK_START,
        ST_WALK_WAIT,
        ST_CHECK,
        ST_EMIT,
        ST_REPORT
    } chg_state_t;

    // Face value in cents of each slot, largest first
    function automatic logic [VAL_W-1:0] denom_value(input logic [SLOT_W-1:0] slot);
        logic [VAL_W-1:0] val;
        unique case (slot)
            4'd0:    val = 15'd20000;
            4'd1:    val = 15'd10000;
            4'd2:    val = 15'd5000;
            4'd3:    val = 15'd2000;
            4'd4:    val = 15'd1000;
            4'd5:    val = 15'd500;
            4'd6:    val = 15'd200;
            4'd7:    val = 15'd100;
            4'd8:    val = 15'd50;
            4'd9:    val = 15'd25;
            4'd10:   val = 15'd10;
            4'd11:   val = 15'd5;
            default: val = 15'd1;
        endcase
        return val;
    endfunction

endpackage

@@ rtl/chg_if.sv @@
// Valid/ready channel interfaces for request items and result items.
`timescale 1ns / 1ps

interface chg_req_if import chg_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic                  op;
    logic [SLOT_W-1:0]     denom_index;
    logic [STOCK_IN_W-1:0] stock_count;
    logic [REM_W-1:0]      price_cents;
    logic [REM_W-1:0]      paid_cents;

    modport source (
        output valid, op, denom_index, stock_count, price_cents, paid_cents,
        input  ready
    );
    modport sink (
        input  valid, op, denom_index, stock_count, price_cents, paid_cents,
        output ready
    );
endinterface

interface chg_rsp_if import chg_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   out_denom;
    logic [PIECES_W-1:0] pieces_used;
    logic [REM_W-1:0]    change_cents;
    logic [BAL_W-1:0]    balance_cents;
    logic                last;

    modport source (
        output valid, status, out_denom, pieces_used, change_cents, balance_cents, last,
        input  ready
    );
    modport sink (
        input  valid, status, out_denom, pieces_used, change_cents, balance_cents, last,
        output ready
    );
endinterface

@@ rtl/greedy_change_dispenser.sv @@
// Top level of the change dispenser: stock store, sequencer and result register.
`timescale 1ns / 1ps

// Cash drawer with a stock count for each of 13 denominations (20000 cents down to
// 1 cent, slot 0 largest); the stock is all zero after reset, with no clearing pass.
// A load reads the old count, multiplies the count change by the face value, adds
// the product to the running balance and reports; a load past the table only
// reports, as does an underpaid or exact sale. A sale with change walks the 13 slots
// in order through one shared shift-subtract-compare unit: a slot with no stock or a
// value above the change left is skipped, any other is worked one bit of the take
// per cycle. A check step follows: with change left the sale reports short of stock,
// else a drain pass over the 13 slots commits the stock and transfers one result per
// slot used. The request side is ready only while the sequencer is idle; a single
// output register holds the result not yet taken; a stalled output holds the drain.
module greedy_change_dispenser import chg_pkg::*; #(
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    chg_req_if.sink   req,
    chg_rsp_if.source rsp
);

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_DENOMS - 1);

    chg_state_t state_reg;
    chg_state_t state_next;

    logic [COUNT_BITS-1:0] stock_q [NUM_DENOMS];
    logic [COUNT_BITS-1:0] tent_q  [NUM_DENOMS];
    logic [BAL_W-1:0]      balance_reg;

    logic [SLOT_W-1:0]     idx_reg;
    logic [COUNT_BITS-1:0] cnt_reg;
    logic [REM_W-1:0]      change_reg;
    logic [REM_W-1:0]      rest_reg;
    logic [SLOT_W-1:0]     slot_reg;
    logic [SLOT_W-1:0]     last_nz_reg;
    chg_status_t           rep_status_reg;
    logic [BAL_W-1:0]      prod_reg;

    logic                  out_valid_reg;
    logic [STATUS_W-1:0]   out_status_reg;
    logic [SLOT_W-1:0]     out_denom_reg;
    logic [PIECES_W-1:0]   out_pieces_reg;
    logic [REM_W-1:0]      out_change_reg;
    logic [BAL_W-1:0]      out_balance_reg;
    logic                  out_last_reg;

    logic                  out_free;
    logic                  out_load;
    logic                  take_start;
    logic                  slot_adv;
    logic                  accept;
    logic [SLOT_W-1:0]     rd_idx;
    logic [COUNT_BITS-1:0] stock_rd;
    logic [COUNT_BITS-1:0] tent_rd;
    logic [VAL_W-1:0]      slot_val;
    logic [BAL_W-1:0]      cnt_wide;
    logic [COUNT_BITS-1:0] cnt_new;
    logic [BAL_W-1:0]      tent_wide;
    logic [BAL_W-1:0]      delta;
    logic                  underpaid;
    logic [REM_W-1:0]      diff;

    logic                  take_done;
    logic [COUNT_BITS-1:0] take_val;
    logic [REM_W-1:0]      take_rem;

    // Shared take unit for the greedy walk
    chg_take_unit #(
        .COUNT_BITS (COUNT_BITS)
    ) u_take (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (take_start),
        .rem_in  (rest_reg),
        .val     (slot_val),
        .avail   (stock_rd),
        .done    (take_done),
        .take    (take_val),
        .rem_out (take_rem)
    );

    // Decode the request and read the stores
    always_comb
    begin
        accept    = req.valid && req.ready;
        rd_idx    = (state_reg == ST_LOAD_MUL) ? idx_reg : slot_reg;
        stock_rd  = stock_q[rd_idx];
        tent_rd   = tent_q[slot_reg];
        slot_val  = denom_value(rd_idx);
        cnt_wide  = BAL_W'(req.stock_count);
        cnt_new   = cnt_wide[COUNT_BITS-1:0];
        tent_wide = BAL_W'(tent_rd);
        delta     = BAL_W'(cnt_reg) - BAL_W'(stock_rd);
        underpaid = req.paid_cents < req.price_cents;
        diff      = req.paid_cents - req.price_cents;
        out_free  = !out_valid_reg || rsp.ready;
    end

    // Next state and sequencer strobes
    always_comb
    begin
        state_next = state_reg;
        take_start = 1'b0;
        out_load   = 1'b0;
        slot_adv   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.op == OP_LOAD)
                    begin
                        state_next = (req.denom_index < SLOT_W'(NUM_DENOMS)) ?
                                     ST_LOAD_MUL : ST_REPORT;
                    end
                    else if (req.paid_cents <= req.price_cents)
                    begin
                        state_next = ST_REPORT;
                    end
                    else
                    begin
                        state_next = ST_WALK_START;
                    end
                end
            end
            ST_LOAD_MUL:
            begin
                state_next = ST_LOAD_ADD;
            end
            ST_LOAD_ADD:
            begin
                state_next = ST_REPORT;
            end
            ST_WALK_START:
            begin
                take_start = 1'b1;
                state_next = ST_WALK_WAIT;
            end
            ST_WALK_WAIT:
            begin
                if (take_done)
                begin
                    state_next = (slot_reg == LAST_SLOT) ? ST_CHECK : ST_WALK_START;
                end
            end
            ST_CHECK:
            begin
                state_next = (rest_reg != '0) ? ST_REPORT : ST_EMIT;
            end
            ST_EMIT:
            begin
                if ((tent_rd == '0) || out_free)
                begin
                    slot_adv = 1'b1;
                    out_load = (tent_rd != '0);
                    if (slot_reg == LAST_SLOT)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_REPORT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold the state, the stock store, the balance and the output flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            balance_reg   <= '0;
            for (int i = 0; i < NUM_DENOMS; i++)
            begin
                stock_q[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == ST_LOAD_MUL)
            begin
                stock_q[idx_reg] <= cnt_reg;
            end
            if (state_reg == ST_LOAD_ADD)
            begin
                balance_reg <= balance_reg + prod_reg;
            end
            if ((state_reg == ST_CHECK) && (rest_reg == '0))
            begin
                balance_reg <= balance_reg - BAL_W'(change_reg);
            end
            // Commit the plan slot by slot during the drain
            if (slot_adv)
            begin
                stock_q[slot_reg] <= stock_rd - tent_rd;
            end
        end
    end

    // Latch the request and step the walk
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            idx_reg     <= req.denom_index;
            cnt_reg     <= cnt_new;
            slot_reg    <= '0;
            last_nz_reg <= '0;
            rest_reg    <= diff;
            if (req.op == OP_LOAD)
            begin
                change_reg     <= '0;
                rep_status_reg <= STATUS_LOADED;
            end
            else
            begin
                change_reg     <= underpaid ? '0 : diff;
                rep_status_reg <= underpaid ? STATUS_UNDERPAID : STATUS_NO_CHANGE;
            end
        end
        if (state_reg == ST_LOAD_MUL)
        begin
            prod_reg <= delta * BAL_W'(slot_val);
        end
        if ((state_reg == ST_WALK_WAIT) && take_done)
        begin
            tent_q[slot_reg] <= take_val;
            rest_reg         <= take_rem;
            if (take_val != '0)
            begin
                last_nz_reg <= slot_reg;
            end
            if (slot_reg != LAST_SLOT)
            begin
                slot_reg <= slot_reg + SLOT_W'(1);
            end
        end
        if (state_reg == ST_CHECK)
        begin
            slot_reg       <= '0;
            rep_status_reg <= STATUS_INSUFFICIENT;
        end
        if (slot_adv && (slot_reg != LAST_SLOT))
        begin
            slot_reg <= slot_reg + SLOT_W'(1);
        end
    end

    // Load the result register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_change_reg  <= change_reg;
            out_balance_reg <= balance_reg;
            if (state_reg == ST_EMIT)
            begin
                out_status_reg <= STATUS_CHANGE_PART;
                out_denom_reg  <= slot_reg;
                out_pieces_reg <= tent_wide[PIECES_W-1:0];
                out_last_reg   <= (slot_reg == last_nz_reg);
            end
            else
            begin
                out_status_reg <= rep_status_reg;
                out_denom_reg  <= '0;
                out_pieces_reg <= '0;
                out_last_reg   <= 1'b1;
            end
        end
    end

    assign req.ready         = (state_reg == ST_IDLE);
    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.out_denom     = out_denom_reg;
    assign rsp.pieces_used   = out_pieces_reg;
    assign rsp.change_cents  = out_change_reg;
    assign rsp.balance_cents = out_balance_reg;
    assign rsp.last          = out_last_reg;

endmodule

@@ rtl/chg_take_unit.sv @@
// Bit-serial unit: largest take <= stock with take * value <= remaining change.
`timescale 1ns / 1ps

module chg_take_unit import chg_pkg::*; #(
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [REM_W-1:0]      rem_in,
    input  logic [VAL_W-1:0]      val,
    input  logic [COUNT_BITS-1:0] avail,
    output logic                  done,
    output logic [COUNT_BITS-1:0] take,
    output logic [REM_W-1:0]      rem_out
);

    localparam int BIT_W   = $clog2(COUNT_BITS);
    localparam int TOP_BIT = ((COUNT_BITS < REM_W) ? COUNT_BITS : REM_W) - 1;

    logic                  busy_reg;
    logic                  done_reg;
    logic [BIT_W-1:0]      bit_reg;
    logic [COUNT_BITS-1:0] take_reg;
    logic [COUNT_BITS-1:0] avail_reg;
    logic [REM_W-1:0]      rem_reg;

    logic [COUNT_BITS-1:0] trial;
    logic [REM_W-1:0]      val_ext;
    logic [REM_W-1:0]      sub;
    logic                  fits;
    logic                  skip;

    // Try one more bit of the take: it must stay within stock and within the change left
    always_comb
    begin
        val_ext = REM_W'(val);
        trial   = take_reg | (COUNT_BITS'(1) << bit_reg);
        sub     = val_ext << bit_reg;
        fits    = (trial <= avail_reg) && ((rem_reg >> bit_reg) >= val_ext);
        skip    = (rem_in < val_ext) || (avail == '0);
    end

    // Hold the control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= !skip;
                done_reg <= skip;
            end
            else if (busy_reg && (bit_reg == '0))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Advance one bit per cycle, most significant first
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg   <= rem_in;
            take_reg  <= '0;
            avail_reg <= avail;
            bit_reg   <= BIT_W'(TOP_BIT);
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                take_reg <= trial;
                rem_reg  <= rem_reg - sub;
            end
            if (bit_reg != '0)
            begin
                bit_reg <= bit_reg - BIT_W'(1);
            end
        end
    end

    assign done    = done_reg;
    assign take    = take_reg;
    assign rem_out = rem_reg;

endmodule

@@ tb/tb_greedy_change_dispenser.sv @@
// Self-checking testbench for greedy_change_dispenser: directed table, random loads and sales.
`timescale 1ns / 1ps

module tb_greedy_change_dispenser;
    import chg_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int RAND_ITEMS  = 105;
    localparam int DRILL_ROWS  = 25;
    localparam int SETTLE      = 300;
    localparam int SHOW_MAX    = 10;
    localparam int MAX_CENTS   = 24'hFFFFFF;

    // One request as the sender drives it
    typedef struct packed {
        logic                  op;
        logic [SLOT_W-1:0]     denom_index;
        logic [STOCK_IN_W-1:0] stock_count;
        logic [REM_W-1:0]      price_cents;
        logic [REM_W-1:0]      paid_cents;
    } drawer_req_t;

    // One result as the drawer should report it
    typedef struct {
        chg_status_t           status;
        logic [SLOT_W-1:0]     out_denom;
        logic [PIECES_W-1:0]   pieces_used;
        logic [REM_W-1:0]      change_cents;
        logic [BAL_W-1:0]      balance_cents;
        logic                  last;
    } drawer_rsp_t;

    // Directed row; typed rows carry their single result in full
    typedef struct packed {
        logic                  op;
        logic [SLOT_W-1:0]     denom_index;
        logic [STOCK_IN_W-1:0] stock_count;
        logic [REM_W-1:0]      price_cents;
        logic [REM_W-1:0]      paid_cents;
        logic                  typed;
        logic [STATUS_W-1:0]   t_status;
        logic [REM_W-1:0]      t_change;
        logic [BAL_W-1:0]      t_balance;
    } drill_row_t;

    drill_row_t drill_tab [DRILL_ROWS] = '{
        // empty drawer: exact payment, underpaid at the extremes, change that cannot be met
        '{OP_SALE, 4'd0,  16'h0000, 24'd0,      24'd0,      1'b1, STATUS_NO_CHANGE,
          24'd0, 32'd0},
        '{OP_SALE, 4'd5,  16'h1234, 24'hFFFFFF, 24'd0,      1'b1, STATUS_UNDERPAID,
          24'd0, 32'd0},
        '{OP_SALE, 4'd0,  16'h0000, 24'd0,      24'hFFFFFF, 1'b1, STATUS_INSUFFICIENT,
          24'hFFFFFF, 32'd0},
        // loads past the table change nothing
        '{OP_LOAD, 4'd15, 16'hFFFF, 24'd0, 24'd0, 1'b1, STATUS_LOADED, 24'd0, 32'd0},
        '{OP_LOAD, 4'd13, 16'h0005, 24'd0, 24'd0, 1'b1, STATUS_LOADED, 24'd0, 32'd0},
        // fill every slot to the top
        '{OP_LOAD, 4'd0,  16'hFFFF, 24'd0, 24'd0, 1'b1, STATUS_LOADED, 24'd0, 32'd1310700000},
        '{OP_LOAD, 4'd12, 16'hFFFF, 24'd0, 24'd0, 1'b1, STATUS_LOADED, 24'd0, 32'd1310765535},
        '{OP_LOAD, 4'd1,  16'hFFFF, 24'd0, 24'd0, 1'b0, STATUS_LOADED, 24'd0, 32'd0},
        '{OP_LOAD, 4'd2,  16'hFFFF, 24'd0, 24'd0, 1'b0, STATUS_LOADED, 24'd0, 32'd0},
        '{OP_LOAD, 4'd3,  16'hFFFF, 24'd0, 24'd0, 1'b0, STATUS_LOADED, 24'd0, 32'd0},
        '{OP_LOAD, 4'd4,  16'hFFFF, 24'd0, 24'd0, 1'b0, STATUS_LOADED, 24'd0, 32'd0},
        '{OP_LOAD, 4'd5,  16'hFFFF, 24'd0, 24'd0, 1'b0, STATUS_LOADED, 24'd0, 32'd0},
        '{OP_LOAD, 4'd6,  16'hFFFF, 24'd0, 24'd0, 1'b0, STATUS_LOADED, 24'd0, 32'd0},
        '{OP_LOAD, 4'd7,  16'hFFFF, 24'd0, 24'd0, 1'b0, STATUS_LOADED, 24'd0, 32'd0},
        '{OP_LOAD, 4'd8,  16'hFFFF, 24'd0, 24'd0, 1'b0, STATUS_LOADED, 24'd0, 32'd0},
        '{OP_LOAD, 4'd9,  16'hFFFF, 24'd0, 24'd0, 1'b0, STATUS_LOADED, 24'd0, 32'd0},
        '{OP_LOAD, 4'd10, 16'hFFFF, 24'd0, 24'd0, 1'b0, STATUS_LOADED, 24'd0, 32'd0},
        '{OP_LOAD, 4'd11, 16'hFFFF, 24'd0, 24'd0, 1'b1, STATUS_LOADED, 24'd0, 32'd2548721685},
        // largest change from a full drawer, then a single cent
        '{OP_SALE, 4'd15, 16'hFFFF, 24'd0, 24'hFFFFFF, 1'b0, STATUS_LOADED, 24'd0, 32'd0},
        '{OP_SALE, 4'd0,  16'h0000, 24'd1, 24'd2,      1'b0, STATUS_LOADED, 24'd0, 32'd0},
        // no cents left: small change falls short
        '{OP_LOAD, 4'd12, 16'h0000, 24'hFFFFFF, 24'hFFFFFF, 1'b0, STATUS_LOADED, 24'd0, 32'd0},
        '{OP_SALE, 4'd12, 16'h0000, 24'd0,      24'd3,      1'b0, STATUS_LOADED, 24'd0, 32'd0},
        // stock limit on the top slot pushes the rest to the next one, then an underpaid sale
        '{OP_LOAD, 4'd0,  16'h0001, 24'd0,   24'd0,     1'b0, STATUS_LOADED, 24'd0, 32'd0},
        '{OP_SALE, 4'd0,  16'h0000, 24'd100, 24'd40100, 1'b0, STATUS_LOADED, 24'd0, 32'd0},
        '{OP_SALE, 4'd0,  16'h0000, 24'd5,   24'd4,     1'b0, STATUS_LOADED, 24'd0, 32'd0}
    };

    int unsigned face_cents [NUM_DENOMS] = '{
        20000, 10000, 5000, 2000, 1000, 500, 200, 100, 50, 25, 10, 5, 1
    };

    logic clk = 1'b0;
    logic rst_n;

    chg_req_if req ();
    chg_rsp_if rsp ();

    greedy_change_dispenser dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // Drawer copy kept by the predictor
    logic [STOCK_IN_W-1:0] stock_model [NUM_DENOMS];
    drawer_rsp_t           pending_results [$];

    int send_idle_pct;
    int recv_idle_pct;
    int error_count   = 0;
    int checked_count = 0;
    int load_count    = 0;
    int sale_count    = 0;
    int status_seen [8] = '{default: 0};
    int cycle_count   = 0;

    always #CLK_HALF clk = ~clk;

    // Build one result with the balance of the drawer as it stands now
    function automatic drawer_rsp_t make_result(input chg_status_t st,
                                                input logic [SLOT_W-1:0] slot,
                                                input logic [PIECES_W-1:0] pieces,
                                                input logic [REM_W-1:0] owed,
                                                input logic lst);
        drawer_rsp_t     r;
        longint unsigned sum;
        sum = 0;
        for (int i = 0; i < NUM_DENOMS; i++)
            sum += longint'(stock_model[i]) * face_cents[i];
        r.status        = st;
        r.out_denom     = slot;
        r.pieces_used   = pieces;
        r.change_cents  = owed;
        r.balance_cents = sum[BAL_W-1:0];
        r.last          = lst;
        return r;
    endfunction

    // Work out the results of one request and update the drawer copy
    function automatic void predict_drawer(input drawer_req_t it, output drawer_rsp_t res[$]);
        logic [REM_W-1:0]    owed;
        int unsigned         left;
        int unsigned         take;
        logic [PIECES_W-1:0] plan [NUM_DENOMS];
        int                  last_slot;
        res = {};
        if (it.op == OP_LOAD)
        begin
            if (it.denom_index < NUM_DENOMS)
                stock_model[it.denom_index] = it.stock_count;
            res.push_back(make_result(STATUS_LOADED, '0, '0, '0, 1'b1));
            return;
        end
        if (it.paid_cents < it.price_cents)
        begin
            res.push_back(make_result(STATUS_UNDERPAID, '0, '0, '0, 1'b1));
            return;
        end
        owed = it.paid_cents - it.price_cents;
        if (owed == 0)
        begin
            res.push_back(make_result(STATUS_NO_CHANGE, '0, '0, '0, 1'b1));
            return;
        end
        // greedy plan, largest slot first, bounded by stock
        left = 32'(owed);
        for (int i = 0; i < NUM_DENOMS; i++)
        begin
            take = 0;
            if (left > 0 && face_cents[i] <= left)
            begin
                take = left / face_cents[i];
                if (take > 32'(stock_model[i]))
                    take = 32'(stock_model[i]);
                left -= take * face_cents[i];
            end
            plan[i] = take[PIECES_W-1:0];
        end
        if (left != 0)
        begin
            res.push_back(make_result(STATUS_INSUFFICIENT, '0, '0, owed, 1'b1));
            return;
        end
        // commit, then one change part per slot used
        last_slot = 0;
        for (int i = 0; i < NUM_DENOMS; i++)
        begin
            stock_model[i] -= plan[i];
            if (plan[i] != 0)
                last_slot = i;
        end
        for (int i = 0; i < NUM_DENOMS; i++)
            if (plan[i] != 0)
                res.push_back(make_result(STATUS_CHANGE_PART, i[SLOT_W-1:0], plan[i], owed,
                                          i == last_slot));
    endfunction

    // Offer one request after a random gap; return once it is transferred
    task automatic send_request(input drawer_req_t it);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid       <= 1'b1;
        req.op          <= it.op;
        req.denom_index <= it.denom_index;
        req.stock_count <= it.stock_count;
        req.price_cents <= it.price_cents;
        req.paid_cents  <= it.paid_cents;
        do
            @(posedge clk);
        while (!req.ready);
        if (it.op == OP_LOAD)
            load_count++;
        else
            sale_count++;
    endtask

    // Drop valid and hold off until the drawer has answered everything
    task automatic drain_results();
        req.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    // Check each result transfer against the oldest expectation; drive ready at random
    always @(posedge clk)
    begin : rsp_check
        drawer_rsp_t want;
        if (rst_n)
        begin
            if (rsp.valid && rsp.ready)
            begin
                checked_count++;
                status_seen[rsp.status]++;
                if (pending_results.size() == 0)
                begin
                    error_count++;
                    if (error_count <= SHOW_MAX)
                        $display("Unexpected result: status=%0d denom=%0d pieces=%0d",
                                 rsp.status, rsp.out_denom, rsp.pieces_used);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (rsp.status !== want.status || rsp.out_denom !== want.out_denom ||
                        rsp.pieces_used !== want.pieces_used ||
                        rsp.change_cents !== want.change_cents ||
                        rsp.balance_cents !== want.balance_cents || rsp.last !== want.last)
                    begin
                        error_count++;
                        if (error_count <= SHOW_MAX)
                        begin
                            $display("Mismatch at result %0d:", checked_count);
                            $display("    expected st=%0d dn=%0d pc=%0d ch=%0d bal=%0d last=%0d",
                                     want.status, want.out_denom, want.pieces_used,
                                     want.change_cents, want.balance_cents, want.last);
                            $display("    got      st=%0d dn=%0d pc=%0d ch=%0d bal=%0d last=%0d",
                                     rsp.status, rsp.out_denom, rsp.pieces_used,
                                     rsp.change_cents, rsp.balance_cents, rsp.last);
                        end
                    end
                end
            end
            rsp.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        drawer_req_t it;
        drawer_rsp_t got [$];
        int unsigned kind;
        int unsigned owed;
        int unsigned price;
        int unsigned cap;

        // hold every input at a known value through reset
        rst_n           = 1'b0;
        req.valid       = 1'b0;
        req.op          = OP_LOAD;
        req.denom_index = '0;
        req.stock_count = '0;
        req.price_cents = '0;
        req.paid_cents  = '0;
        rsp.ready       = 1'b0;
        for (int i = 0; i < NUM_DENOMS; i++)
            stock_model[i] = '0;
        send_idle_pct = 35;
        recv_idle_pct = 54;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // walk the directed table
        for (int r = 0; r < DRILL_ROWS; r++)
        begin
            it = '{drill_tab[r].op, drill_tab[r].denom_index, drill_tab[r].stock_count,
                   drill_tab[r].price_cents, drill_tab[r].paid_cents};
            send_request(it);
            predict_drawer(it, got);
            if (drill_tab[r].typed)
                pending_results.push_back('{chg_status_t'(drill_tab[r].t_status), '0, '0,
                                            drill_tab[r].t_change, drill_tab[r].t_balance,
                                            1'b1});
            else
                foreach (got[k])
                    pending_results.push_back(got[k]);
        end

        // random loads and sales; swap, then drop, idling at each third
        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            if (n == RAND_ITEMS / 3)
            begin
                drain_results();
                send_idle_pct = 54;
                recv_idle_pct = 35;
            end
            else if (n == 2 * RAND_ITEMS / 3)
            begin
                drain_results();
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            kind = $urandom_range(0, 99);
            if (kind < 35)
            begin
                it.op          = OP_LOAD;
                it.denom_index = SLOT_W'($urandom_range(0, 15));
                kind = $urandom_range(0, 99);
                if (kind < 70)
                    it.stock_count = STOCK_IN_W'($urandom_range(0, 40));
                else if (kind < 90)
                    it.stock_count = STOCK_IN_W'($urandom_range(0, 16'hFFFF));
                else
                    it.stock_count = (kind < 95) ? 16'hFFFF : 16'h0000;
                it.price_cents = REM_W'($urandom_range(0, MAX_CENTS));
                it.paid_cents  = REM_W'($urandom_range(0, MAX_CENTS));
            end
            else
            begin
                it.op          = OP_SALE;
                it.denom_index = SLOT_W'($urandom_range(0, 15));
                it.stock_count = STOCK_IN_W'($urandom_range(0, 16'hFFFF));
                kind = $urandom_range(0, 99);
                if (kind < 8)
                begin
                    price = $urandom_range(1, MAX_CENTS);
                    it.price_cents = price[REM_W-1:0];
                    it.paid_cents  = REM_W'($urandom_range(0, price - 1));
                end
                else if (kind < 14)
                begin
                    price = $urandom_range(0, MAX_CENTS);
                    it.price_cents = price[REM_W-1:0];
                    it.paid_cents  = price[REM_W-1:0];
                end
                else
                begin
                    // mostly change that the drawer can cover, some arbitrary amounts
                    owed = 0;
                    if (kind < 70)
                    begin
                        for (int i = 0; i < NUM_DENOMS; i++)
                        begin
                            cap = (stock_model[i] < 3) ? 32'(stock_model[i]) : 3;
                            if ($urandom_range(0, 2) == 0)
                                owed += $urandom_range(0, cap) * face_cents[i];
                        end
                        if (owed == 0)
                            owed = $urandom_range(1, 99);
                    end
                    else if (kind < 92)
                    begin
                        owed = $urandom_range(1, 5000);
                    end
                    else
                    begin
                        owed = $urandom_range(1, MAX_CENTS);
                    end
                    price = $urandom_range(0, MAX_CENTS - owed);
                    it.price_cents = price[REM_W-1:0];
                    it.paid_cents  = REM_W'(price + owed);
                end
            end
            send_request(it);
            predict_drawer(it, got);
            foreach (got[k])
                pending_results.push_back(got[k]);
        end

        // let the last results arrive, then watch for strays
        drain_results();
        repeat (SETTLE) @(posedge clk);

        $display("Ran %0d loads, %0d sales: %0d change parts, %0d exact, %0d underpaid,",
                 load_count, sale_count, status_seen[STATUS_CHANGE_PART],
                 status_seen[STATUS_NO_CHANGE], status_seen[STATUS_UNDERPAID]);
        $display("%0d short of stock, %0d loaded; %0d results checked, %0d failures.",
                 status_seen[STATUS_INSUFFICIENT], status_seen[STATUS_LOADED],
                 checked_count, error_count);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ files.f @@
rtl/chg_pkg.sv
rtl/chg_if.sv
rtl/chg_take_unit.sv
rtl/greedy_change_dispenser.sv
tb/tb_greedy_change_dispenser.sv
